[rtl/interval_compare_fold_refine_assert.svh]
// Assertion macros shared by the interval compare block.
`ifndef INTERVAL_COMPARE_FOLD_REFINE_ASSERT_SVH
`define INTERVAL_COMPARE_FOLD_REFINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ICFR_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ICFR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/icfr_pkg.sv]
package icfr_pkg;

  // Comparison opcodes as carried in the operation field.
  localparam logic [3:0] OP_EQ  = 4'd0;
  localparam logic [3:0] OP_NE  = 4'd1;
  localparam logic [3:0] OP_SLT = 4'd2;
  localparam logic [3:0] OP_SGT = 4'd3;
  localparam logic [3:0] OP_SLE = 4'd4;
  localparam logic [3:0] OP_SGE = 4'd5;
  localparam logic [3:0] OP_UGT = 4'd6;
  localparam logic [3:0] OP_ULT = 4'd7;
  localparam logic [3:0] OP_UGE = 4'd8;
  localparam logic [3:0] OP_ULE = 4'd9;

  // Relation class after the opcode is resolved.
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_LT,
    KIND_LE,
    KIND_GT,
    KIND_GE
  } kind_e;

  // Input item.
  typedef struct packed {
    logic [3:0]         operation;
    logic               invert;
    logic signed [31:0] left_low;
    logic signed [31:0] left_high;
    logic signed [31:0] right_low;
    logic signed [31:0] right_high;
  } icfr_in_t;

  // Result item.
  typedef struct packed {
    logic               decided;
    logic               outcome;
    logic               narrowed;
    logic signed [31:0] new_left_low;
    logic signed [31:0] new_left_high;
    logic signed [31:0] new_right_low;
    logic signed [31:0] new_right_high;
    logic               left_empty;
    logic               right_empty;
  } icfr_out_t;

  // Logical inverse of an opcode; codes without meaning map to themselves.
  function automatic logic [3:0] inverse_op(input logic [3:0] op);
    logic [3:0] res;
    unique case (op)
      OP_EQ:   res = OP_NE;
      OP_NE:   res = OP_EQ;
      OP_SLT:  res = OP_SGE;
      OP_SGT:  res = OP_SLE;
      OP_SLE:  res = OP_SGT;
      OP_SGE:  res = OP_SLT;
      OP_UGT:  res = OP_ULE;
      OP_ULT:  res = OP_UGE;
      OP_UGE:  res = OP_ULT;
      OP_ULE:  res = OP_UGT;
      default: res = op;
    endcase
    return res;
  endfunction

endpackage

[rtl/icfr_core.sv]
module icfr_core #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  icfr_pkg::icfr_in_t  item_i,
  output icfr_pkg::icfr_out_t result_o
);

  localparam int unsigned W = VALUE_WIDTH;

  // Bounds are worked one bit wider so that a step of one never wraps.
  localparam logic signed [W:0] ValMin = {2'b11, {(W - 1){1'b0}}};
  localparam logic signed [W:0] ValMax = {2'b00, {(W - 1){1'b1}}};
  localparam logic signed [W:0] One    = {{W{1'b0}}, 1'b1};

  logic [3:0]        op;
  logic signed [W:0] ll, lh, rl, rh;
  logic signed [W:0] nll, nlh, nrl, nrh;
  logic signed [W:0] fll, flh, frl, frh;
  logic              decided, outcome, disjoint, same, unsigned_ok;
  logic              lempty, rempty;
  icfr_pkg::kind_e   kind;

  // Resolve the effective opcode and widen the bounds.
  always_comb begin
    op = item_i.invert ? icfr_pkg::inverse_op(item_i.operation) : item_i.operation;
    ll = (W + 1)'(signed'(item_i.left_low[W-1:0]));
    lh = (W + 1)'(signed'(item_i.left_high[W-1:0]));
    rl = (W + 1)'(signed'(item_i.right_low[W-1:0]));
    rh = (W + 1)'(signed'(item_i.right_high[W-1:0]));
  end

  // Map the opcode to a relation class; unsigned kinds need non-negative lows.
  always_comb begin
    unsigned_ok = !ll[W] && !rl[W];
    kind        = icfr_pkg::KIND_NONE;
    unique case (op)
      icfr_pkg::OP_SLT: kind = icfr_pkg::KIND_LT;
      icfr_pkg::OP_SGT: kind = icfr_pkg::KIND_GT;
      icfr_pkg::OP_SLE: kind = icfr_pkg::KIND_LE;
      icfr_pkg::OP_SGE: kind = icfr_pkg::KIND_GE;
      icfr_pkg::OP_UGT: kind = unsigned_ok ? icfr_pkg::KIND_GT : icfr_pkg::KIND_NONE;
      icfr_pkg::OP_ULT: kind = unsigned_ok ? icfr_pkg::KIND_LT : icfr_pkg::KIND_NONE;
      icfr_pkg::OP_UGE: kind = unsigned_ok ? icfr_pkg::KIND_GE : icfr_pkg::KIND_NONE;
      icfr_pkg::OP_ULE: kind = unsigned_ok ? icfr_pkg::KIND_LE : icfr_pkg::KIND_NONE;
      default:          kind = icfr_pkg::KIND_NONE;
    endcase
  end

  // Decide the outcome and clip the bounds that face the other operand.
  always_comb begin
    disjoint = (lh < rl) || (rh < ll);
    same     = (ll == lh) && (rl == rh) && (ll == rl);
    decided  = 1'b0;
    outcome  = 1'b0;
    nll      = ll;
    nlh      = lh;
    nrl      = rl;
    nrh      = rh;
    if (op == icfr_pkg::OP_EQ || op == icfr_pkg::OP_NE) begin
      if (disjoint) begin
        decided = 1'b1;
        outcome = (op == icfr_pkg::OP_NE);
      end else if (same) begin
        decided = 1'b1;
        outcome = (op == icfr_pkg::OP_EQ);
      end
      if (op == icfr_pkg::OP_EQ) begin
        nll = (ll > rl) ? ll : rl;
        nlh = (lh < rh) ? lh : rh;
        nrl = nll;
        nrh = nlh;
      end
    end
    unique case (kind)
      icfr_pkg::KIND_LT: begin
        if (lh < rl) begin
          decided = 1'b1;
          outcome = 1'b1;
        end else if (ll >= rh) begin
          decided = 1'b1;
        end
        nlh = (lh < rh - One) ? lh : rh - One;
        nrl = (rl > ll + One) ? rl : ll + One;
      end
      icfr_pkg::KIND_LE: begin
        if (lh <= rl) begin
          decided = 1'b1;
          outcome = 1'b1;
        end else if (ll > rh) begin
          decided = 1'b1;
        end
        nlh = (lh < rh) ? lh : rh;
        nrl = (rl > ll) ? rl : ll;
      end
      icfr_pkg::KIND_GT: begin
        if (ll > rh) begin
          decided = 1'b1;
          outcome = 1'b1;
        end else if (lh <= rl) begin
          decided = 1'b1;
        end
        nll = (ll > rl + One) ? ll : rl + One;
        nrh = (rh < lh - One) ? rh : lh - One;
      end
      icfr_pkg::KIND_GE: begin
        if (ll >= rh) begin
          decided = 1'b1;
          outcome = 1'b1;
        end else if (lh < rl) begin
          decided = 1'b1;
        end
        nll = (ll > rl) ? ll : rl;
        nrh = (rh < lh) ? rh : lh;
      end
      default: ;
    endcase
  end

  // Replace an empty interval by the full range and flag it.
  always_comb begin
    lempty = nll > nlh;
    rempty = nrl > nrh;
    fll    = lempty ? ValMin : nll;
    flh    = lempty ? ValMax : nlh;
    frl    = rempty ? ValMin : nrl;
    frh    = rempty ? ValMax : nrh;
  end

  // Pack the result, sign-extending the bounds to the port width.
  always_comb begin
    result_o.decided        = decided;
    result_o.outcome        = outcome;
    result_o.narrowed       = (fll > ll) || (flh < lh) || (frl > rl) || (frh < rh);
    result_o.new_left_low   = 32'(signed'(fll[W-1:0]));
    result_o.new_left_high  = 32'(signed'(flh[W-1:0]));
    result_o.new_right_low  = 32'(signed'(frl[W-1:0]));
    result_o.new_right_high = 32'(signed'(frh[W-1:0]));
    result_o.left_empty     = lempty;
    result_o.right_empty    = rempty;
  end

endmodule

[rtl/interval_compare_fold_refine.sv]
// Each item is held in the input register, then its result in the result
// register, which drives the output.
// Throughput: one item per cycle while the output is not stalled; the comparison
// and clipping logic between the two registers is the only work stage.
// Reset clears the two stage valid bits; payload registers are not reset.
module interval_compare_fold_refine #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  icfr_pkg::icfr_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output icfr_pkg::icfr_out_t out_data_o
);

  `include "interval_compare_fold_refine_assert.svh"

  logic                s1_valid_q, s2_valid_q;
  logic                s1_adv, s2_load;
  icfr_pkg::icfr_in_t  s1_data_q;
  icfr_pkg::icfr_out_t core_res, s2_data_q;

  // Each stage moves on when the stage after it is empty or draining.
  assign s2_load    = !s2_valid_q || out_ready_i;
  assign s1_adv     = s2_load;
  assign in_ready_o = !s1_valid_q || s1_adv;

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_load) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
  end

  icfr_core #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_core (
    .item_i  (s1_data_q),
    .result_o(core_res)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_load) begin
      s2_data_q <= core_res;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_data_q;

  // Checks on the pipeline control and on the result encoding.
  `ICFR_ASSERT_NOW(a_stall_full, clk_i, rst_ni, !in_ready_o,
                   s1_valid_q && s2_valid_q, "input stalled while a stage is empty")
  `ICFR_ASSERT_NEXT(a_stage_moves, clk_i, rst_ni, s1_valid_q && s1_adv,
                    s2_valid_q, "item lost between stages")
  `ICFR_ASSERT_NOW(a_outcome_decided, clk_i, rst_ni, out_valid_o && !out_data_o.decided,
                   !out_data_o.outcome, "outcome set while undecided")
  `ICFR_ASSERT_NOW(a_empty_full, clk_i, rst_ni, out_valid_o && out_data_o.left_empty,
                   !out_data_o.new_left_low[VALUE_WIDTH-2] &&
                   out_data_o.new_left_high[VALUE_WIDTH-2],
                   "empty left interval not replaced by full range")

endmodule
